### src/tcot_pkg.sv
// shared widths, types and reason codes of the triangle and circle overlap test
package tcot_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 15;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HALF_W = COORD_WIDTH + 1;
    localparam int RR_W   = 2 * RADIUS_WIDTH;
    localparam int SQ_W   = 4 * HALF_W;
    localparam int RD_W   = RR_W + 2 * HALF_W;
    localparam int CMP_W  = (SQ_W > RD_W) ? SQ_W : RD_W;
    localparam int PT_W   = (SUM_W > RR_W + 1) ? SUM_W : RR_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [RADIUS_WIDTH-1:0] t_radius;

    typedef enum logic [2:0] {
        REASON_NONE   = 3'd0,
        REASON_CENTRE = 3'd1,
        REASON_AB     = 3'd2,
        REASON_BC     = 3'd3,
        REASON_CA     = 3'd4
    } t_reason;

    typedef struct packed {
        t_coord  ax;
        t_coord  ay;
        t_coord  bx;
        t_coord  by;
        t_coord  cx;
        t_coord  cy;
        t_coord  centre_x;
        t_coord  centre_y;
        t_radius radius;
    } t_tri_in;

    typedef struct packed {
        logic       hit;
        logic [2:0] hit_reason;
    } t_tri_out;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        logic inside_ok;
        logic hit;
    } t_edge_res;

endpackage

### src/tcot_edge_unit.sv
// six-stage pipeline for one directed edge: side sign and disc-to-segment test
module tcot_edge_unit import tcot_pkg::*; (
    input  logic      i_clk,
    input  t_point    i_p,
    input  t_point    i_q,
    input  t_point    i_s,
    input  t_radius   i_radius,
    output t_edge_res o_res
);

    // stage 1: differences
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_wx, r1_wy, r1_ex, r1_ey;
    logic [RR_W-1:0]          r1_rr;

    always_ff @(posedge i_clk) begin
        r1_dx <= DIFF_W'(i_q.x) - DIFF_W'(i_p.x);
        r1_dy <= DIFF_W'(i_q.y) - DIFF_W'(i_p.y);
        r1_wx <= DIFF_W'(i_s.x) - DIFF_W'(i_p.x);
        r1_wy <= DIFF_W'(i_s.y) - DIFF_W'(i_p.y);
        r1_ex <= DIFF_W'(i_s.x) - DIFF_W'(i_q.x);
        r1_ey <= DIFF_W'(i_s.y) - DIFF_W'(i_q.y);
        r1_rr <= i_radius * i_radius;
    end

    // stage 2: products
    logic signed [PROD_W-1:0] r2_crp, r2_crn, r2_dxx, r2_dyy, r2_nx, r2_ny;
    logic signed [PROD_W-1:0] r2_wxx, r2_wyy, r2_exx, r2_eyy;
    logic [RR_W-1:0]          r2_rr;

    always_ff @(posedge i_clk) begin
        r2_crp <= r1_wx * r1_dy;
        r2_crn <= r1_wy * r1_dx;
        r2_dxx <= r1_dx * r1_dx;
        r2_dyy <= r1_dy * r1_dy;
        r2_nx  <= r1_wx * r1_dx;
        r2_ny  <= r1_wy * r1_dy;
        r2_wxx <= r1_wx * r1_wx;
        r2_wyy <= r1_wy * r1_wy;
        r2_exx <= r1_ex * r1_ex;
        r2_eyy <= r1_ey * r1_ey;
        r2_rr  <= r1_rr;
    end

    // stage 3: sums
    logic signed [SUM_W-1:0] r3_cr, r3_den, r3_num, r3_dp, r3_dq;
    logic [RR_W-1:0]         r3_rr;

    always_ff @(posedge i_clk) begin
        r3_cr  <= SUM_W'(r2_crp) - SUM_W'(r2_crn);
        r3_den <= SUM_W'(r2_dxx) + SUM_W'(r2_dyy);
        r3_num <= SUM_W'(r2_nx) + SUM_W'(r2_ny);
        r3_dp  <= SUM_W'(r2_wxx) + SUM_W'(r2_wyy);
        r3_dq  <= SUM_W'(r2_exx) + SUM_W'(r2_eyy);
        r3_rr  <= r2_rr;
    end

    // stage 4: classification, point tests and partial products
    logic signed [SUM_W-1:0] cr_abs;
    logic [2*HALF_W-1:0]     acr, den_u;
    logic signed [PT_W-1:0]  rr_pt;
    logic                    use_p, use_q, pt_hit;

    assign cr_abs = r3_cr[SUM_W-1] ? -r3_cr : r3_cr;
    assign acr    = cr_abs[2*HALF_W-1:0];
    assign den_u  = r3_den[2*HALF_W-1:0];
    assign rr_pt  = PT_W'(signed'({1'b0, r3_rr}));
    assign use_p  = (r3_den == '0) || r3_num[SUM_W-1] || (r3_num == '0);
    assign use_q  = !use_p && (r3_num >= r3_den);
    assign pt_hit = use_p ? (PT_W'(r3_dp) <= rr_pt)
                  : (use_q ? (PT_W'(r3_dq) <= rr_pt) : 1'b0);

    logic [2*HALF_W-1:0]      r4_hh, r4_hl, r4_ll;
    logic [RR_W+HALF_W-1:0]   r4_rh, r4_rl;
    logic                     r4_pt_hit, r4_interior, r4_inside_ok;

    always_ff @(posedge i_clk) begin
        r4_hh        <= acr[2*HALF_W-1:HALF_W] * acr[2*HALF_W-1:HALF_W];
        r4_hl        <= acr[2*HALF_W-1:HALF_W] * acr[HALF_W-1:0];
        r4_ll        <= acr[HALF_W-1:0] * acr[HALF_W-1:0];
        r4_rh        <= r3_rr * den_u[2*HALF_W-1:HALF_W];
        r4_rl        <= r3_rr * den_u[HALF_W-1:0];
        r4_pt_hit    <= pt_hit;
        r4_interior  <= !use_p && !use_q;
        r4_inside_ok <= !r3_cr[SUM_W-1];
    end

    // stage 5: assemble cross squared and radius squared times length squared
    logic [SQ_W-1:0] r5_sq;
    logic [RD_W-1:0] r5_rd;
    logic            r5_pt_hit, r5_interior, r5_inside_ok;

    always_ff @(posedge i_clk) begin
        r5_sq        <= (SQ_W'(r4_hh) << (2 * HALF_W)) + (SQ_W'(r4_hl) << (HALF_W + 1))
                      + SQ_W'(r4_ll);
        r5_rd        <= (RD_W'(r4_rh) << HALF_W) + RD_W'(r4_rl);
        r5_pt_hit    <= r4_pt_hit;
        r5_interior  <= r4_interior;
        r5_inside_ok <= r4_inside_ok;
    end

    // stage 6: final compare
    t_edge_res r6_res;

    always_ff @(posedge i_clk) begin
        r6_res.hit       <= r5_pt_hit
                          | (r5_interior & (CMP_W'(r5_sq) <= CMP_W'(r5_rd)));
        r6_res.inside_ok <= r5_inside_ok;
    end

    assign o_res = r6_res;

endmodule

### src/triangle_circle_overlap_test_unit.sv
// top level of the triangle and circle overlap test pipeline
// Fully pipelined: one transaction is taken on every clock in which i_start is high, and
// o_busy stays low. Each result appears as a one-cycle o_done strobe with o_result, once
// it has passed the three six-stage edge pipelines, which work in parallel, and the
// output register that merges their flags into the reason code; results come in the
// order of the transactions and must be taken in that cycle, since the receiver cannot
// stall the block.
module triangle_circle_overlap_test_unit import tcot_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    input  t_tri_in  i_data,
    output logic     o_done,
    output t_tri_out o_result
);

    localparam int EDGE_LAT = 6;

    t_point    pt_a, pt_b, pt_c, pt_s;
    t_edge_res res_ab, res_bc, res_ca;

    assign pt_a   = '{x: i_data.ax, y: i_data.ay};
    assign pt_b   = '{x: i_data.bx, y: i_data.by};
    assign pt_c   = '{x: i_data.cx, y: i_data.cy};
    assign pt_s   = '{x: i_data.centre_x, y: i_data.centre_y};
    assign o_busy = 1'b0;

    tcot_edge_unit u_edge_ab (
        .i_clk    (i_clk),
        .i_p      (pt_a),
        .i_q      (pt_b),
        .i_s      (pt_s),
        .i_radius (i_data.radius),
        .o_res    (res_ab)
    );

    tcot_edge_unit u_edge_bc (
        .i_clk    (i_clk),
        .i_p      (pt_b),
        .i_q      (pt_c),
        .i_s      (pt_s),
        .i_radius (i_data.radius),
        .o_res    (res_bc)
    );

    tcot_edge_unit u_edge_ca (
        .i_clk    (i_clk),
        .i_p      (pt_c),
        .i_q      (pt_a),
        .i_s      (pt_s),
        .i_radius (i_data.radius),
        .o_res    (res_ca)
    );

    logic [EDGE_LAT-1:0] r_vld;
    logic                r_done;
    t_tri_out            r_result;
    t_reason             n_reason;

    always_comb begin
        if (res_ab.inside_ok && res_bc.inside_ok && res_ca.inside_ok) begin
            n_reason = REASON_CENTRE;
        end else if (res_ab.hit) begin
            n_reason = REASON_AB;
        end else if (res_bc.hit) begin
            n_reason = REASON_BC;
        end else if (res_ca.hit) begin
            n_reason = REASON_CA;
        end else begin
            n_reason = REASON_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[EDGE_LAT-2:0], i_start};
            r_done <= r_vld[EDGE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.hit        <= (n_reason != REASON_NONE);
        r_result.hit_reason <= n_reason;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##7 o_done)
        else $error("transaction did not produce a result after the pipeline latency");

    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 7))
        else $error("result strobe without a matching transaction");

    a_hit_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.hit == (o_result.hit_reason != REASON_NONE)))
        else $error("hit flag disagrees with reason code");

    a_point_triangle_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_data.ax == i_data.bx && i_data.bx == i_data.cx
         && i_data.ay == i_data.by && i_data.by == i_data.cy)
        |-> ##7 (o_result.hit_reason == REASON_CENTRE))
        else $error("triangle of three equal vertices must report centre inside");

endmodule
